[rtl/caf_pkg.sv]
package caf_pkg;

   // Default widths of the datapath.
   localparam int POSITION_BITS_DEF  = 16;
   localparam int SHARPNESS_BITS_DEF = 16;
   localparam int SETTLE_BITS_DEF    = 8;

   // Fixed widths of the register file.
   localparam int CSR_INDEX_BITS     = 3;
   localparam int CSR_DATA_BITS      = 32;
   localparam int DROP_RATIO_BITS    = 9;
   localparam int SETTLE_FRAMES_BITS = 8;

   // Reset values of the registers.
   localparam int FOCUS_MIN_RST          = 0;
   localparam int FOCUS_MAX_RST          = 25600;
   localparam int SCAN_STEP_RST          = 512;
   localparam int TRACK_STEP_RST         = 128;
   localparam int DROP_RATIO_RST         = 192;
   localparam int SETTLE_FRAMES_RST      = 2;
   localparam int MIN_BEST_SHARPNESS_RST = 0;

   // Register indexes.
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FOCUS_MIN          = 3'd0,
      CSR_FOCUS_MAX          = 3'd1,
      CSR_SCAN_STEP          = 3'd2,
      CSR_TRACK_STEP         = 3'd3,
      CSR_DROP_RATIO         = 3'd4,
      CSR_SETTLE_FRAMES      = 3'd5,
      CSR_MIN_BEST_SHARPNESS = 3'd6
   } csr_index_type;

endpackage

[rtl/caf_req_if.sv]
interface caf_req_if #(
   parameter int POSITION_BITS  = caf_pkg::POSITION_BITS_DEF,
   parameter int SHARPNESS_BITS = caf_pkg::SHARPNESS_BITS_DEF
);
   logic                      valid;
   logic                      ready;
   logic [SHARPNESS_BITS-1:0] frame_sharpness;
   logic [POSITION_BITS-1:0]  current_position;

   modport source (output valid, frame_sharpness, current_position, input ready);
   modport sink   (input valid, frame_sharpness, current_position, output ready);
endinterface

[rtl/caf_rsp_if.sv]
interface caf_rsp_if #(
   parameter int POSITION_BITS  = caf_pkg::POSITION_BITS_DEF,
   parameter int SHARPNESS_BITS = caf_pkg::SHARPNESS_BITS_DEF
);
   logic                      valid;
   logic                      ready;
   logic [POSITION_BITS-1:0]  next_position;
   logic                      tracking;
   logic [POSITION_BITS-1:0]  best_position_out;
   logic [SHARPNESS_BITS-1:0] best_sharpness_out;

   modport source (output valid, next_position, tracking, best_position_out,
                   best_sharpness_out, input ready);
   modport sink   (input valid, next_position, tracking, best_position_out,
                   best_sharpness_out, output ready);
endinterface

[rtl/caf_csr_if.sv]
interface caf_csr_if;
   logic                               valid;
   logic                               ready;
   logic [caf_pkg::CSR_INDEX_BITS-1:0] index;
   logic [caf_pkg::CSR_DATA_BITS-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[rtl/contrast_autofocus_hill_climb.sv]
// Contrast-detection autofocus by hill climbing. Each transfer on the request
// channel carries one frame's sharpness and the lens position it was taken at;
// each transfer on the response channel returns the lens position for the next
// frame, the mode (scan or track) and the best position and sharpness so far.
// Registers are written through the CSR channel, which is always ready; the
// user must write them only while no frame is in flight, which the block
// itself does not enforce. One frame is accepted every clock cycle when the
// response side keeps up; a result passes through the input register, then
// the result register, which is loaded at the same edge as the focus state.
// The rate is set by the focus state update, which carries the focus state
// from each frame into the next.
module contrast_autofocus_hill_climb #(
   parameter int POSITION_BITS  = caf_pkg::POSITION_BITS_DEF,
   parameter int SHARPNESS_BITS = caf_pkg::SHARPNESS_BITS_DEF,
   parameter int SETTLE_BITS    = caf_pkg::SETTLE_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   caf_req_if.sink    req_ch,
   caf_rsp_if.source  rsp_ch,
   caf_csr_if.sink    csr_ch
);
   import caf_pkg::*;

   // Configuration values.
   logic [POSITION_BITS-1:0]      focus_min;
   logic [POSITION_BITS-1:0]      focus_max;
   logic [POSITION_BITS-1:0]      scan_step;
   logic [POSITION_BITS-1:0]      track_step;
   logic [DROP_RATIO_BITS-1:0]    drop_ratio;
   logic [SETTLE_FRAMES_BITS-1:0] settle_frames;
   logic [SHARPNESS_BITS-1:0]     min_best_sharpness;

   // Input register.
   logic                          in_valid_ff;
   logic [SHARPNESS_BITS-1:0]     in_sharp_ff;
   logic [POSITION_BITS-1:0]      in_pos_ff;

   // Focus state.
   logic                          mode_track_ff;
   logic [SHARPNESS_BITS-1:0]     best_sharpness_ff;
   logic [POSITION_BITS-1:0]      best_position_ff;
   logic [SHARPNESS_BITS-1:0]     last_sharpness_ff;
   logic                          moving_down_ff;
   logic [SETTLE_BITS-1:0]        settle_count_ff;
   logic                          mode_track_in;
   logic [SHARPNESS_BITS-1:0]     best_sharpness_in;
   logic [POSITION_BITS-1:0]      best_position_in;
   logic [SHARPNESS_BITS-1:0]     last_sharpness_in;
   logic                          moving_down_in;
   logic [SETTLE_BITS-1:0]        settle_count_in;
   logic [POSITION_BITS-1:0]      next_position;

   // Result register.
   logic                          out_valid_ff;
   logic [POSITION_BITS-1:0]      out_next_ff;
   logic                          out_tracking_ff;
   logic [POSITION_BITS-1:0]      out_best_pos_ff;
   logic [SHARPNESS_BITS-1:0]     out_best_sharp_ff;

   logic                          advance;
   logic                          req_xfer;

   caf_csr_regs #(
      .POSITION_BITS  (POSITION_BITS),
      .SHARPNESS_BITS (SHARPNESS_BITS)
   ) u_csr_regs (
      .clock              (clock),
      .reset              (reset),
      .csr_ch             (csr_ch),
      .focus_min          (focus_min),
      .focus_max          (focus_max),
      .scan_step          (scan_step),
      .track_step         (track_step),
      .drop_ratio         (drop_ratio),
      .settle_frames      (settle_frames),
      .min_best_sharpness (min_best_sharpness)
   );

   caf_step #(
      .POSITION_BITS  (POSITION_BITS),
      .SHARPNESS_BITS (SHARPNESS_BITS),
      .SETTLE_BITS    (SETTLE_BITS)
   ) u_step (
      .focus_min          (focus_min),
      .focus_max          (focus_max),
      .scan_step          (scan_step),
      .track_step         (track_step),
      .drop_ratio         (drop_ratio),
      .settle_frames      (settle_frames),
      .min_best_sharpness (min_best_sharpness),
      .sharp              (in_sharp_ff),
      .pos                (in_pos_ff),
      .mode_track         (mode_track_ff),
      .best_sharpness     (best_sharpness_ff),
      .best_position      (best_position_ff),
      .last_sharpness     (last_sharpness_ff),
      .moving_down        (moving_down_ff),
      .settle_count       (settle_count_ff),
      .mode_track_in      (mode_track_in),
      .best_sharpness_in  (best_sharpness_in),
      .best_position_in   (best_position_in),
      .last_sharpness_in  (last_sharpness_in),
      .moving_down_in     (moving_down_in),
      .settle_count_in    (settle_count_in),
      .next_position      (next_position)
   );

   // The held frame moves on when the result register is free or being emptied.
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_xfer     = req_ch.valid && req_ch.ready;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_sharp_ff <= req_ch.frame_sharpness;
         in_pos_ff   <= req_ch.current_position;
      end
   end

   // Focus state update, one frame per advance.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_track_ff     <= 1'b0;
         best_sharpness_ff <= '0;
         best_position_ff  <= '0;
         last_sharpness_ff <= '0;
         moving_down_ff    <= 1'b0;
         settle_count_ff   <= '0;
      end else if (advance) begin
         mode_track_ff     <= mode_track_in;
         best_sharpness_ff <= best_sharpness_in;
         best_position_ff  <= best_position_in;
         last_sharpness_ff <= last_sharpness_in;
         moving_down_ff    <= moving_down_in;
         settle_count_ff   <= settle_count_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_next_ff       <= next_position;
         out_tracking_ff   <= mode_track_in;
         out_best_pos_ff   <= best_position_in;
         out_best_sharp_ff <= best_sharpness_in;
      end
   end

   assign rsp_ch.valid              = out_valid_ff;
   assign rsp_ch.next_position      = out_next_ff;
   assign rsp_ch.tracking           = out_tracking_ff;
   assign rsp_ch.best_position_out  = out_best_pos_ff;
   assign rsp_ch.best_sharpness_out = out_best_sharp_ff;

endmodule

[rtl/caf_csr_regs.sv]
module caf_csr_regs #(
   parameter int POSITION_BITS  = caf_pkg::POSITION_BITS_DEF,
   parameter int SHARPNESS_BITS = caf_pkg::SHARPNESS_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   caf_csr_if.sink                                csr_ch,
   output logic [POSITION_BITS-1:0]               focus_min,
   output logic [POSITION_BITS-1:0]               focus_max,
   output logic [POSITION_BITS-1:0]               scan_step,
   output logic [POSITION_BITS-1:0]               track_step,
   output logic [caf_pkg::DROP_RATIO_BITS-1:0]    drop_ratio,
   output logic [caf_pkg::SETTLE_FRAMES_BITS-1:0] settle_frames,
   output logic [SHARPNESS_BITS-1:0]              min_best_sharpness
);
   import caf_pkg::*;

   logic [POSITION_BITS-1:0]      focus_min_ff;
   logic [POSITION_BITS-1:0]      focus_max_ff;
   logic [POSITION_BITS-1:0]      scan_step_ff;
   logic [POSITION_BITS-1:0]      track_step_ff;
   logic [DROP_RATIO_BITS-1:0]    drop_ratio_ff;
   logic [SETTLE_FRAMES_BITS-1:0] settle_frames_ff;
   logic [SHARPNESS_BITS-1:0]     min_best_sharpness_ff;
   logic                          write_en;

   // Always ready; software must configure the block only when idle, unchecked.
   assign csr_ch.ready = 1'b1;
   assign write_en     = csr_ch.valid;

   // Register file with its reset values; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         focus_min_ff          <= POSITION_BITS'(FOCUS_MIN_RST);
         focus_max_ff          <= POSITION_BITS'(FOCUS_MAX_RST);
         scan_step_ff          <= POSITION_BITS'(SCAN_STEP_RST);
         track_step_ff         <= POSITION_BITS'(TRACK_STEP_RST);
         drop_ratio_ff         <= DROP_RATIO_BITS'(DROP_RATIO_RST);
         settle_frames_ff      <= SETTLE_FRAMES_BITS'(SETTLE_FRAMES_RST);
         min_best_sharpness_ff <= SHARPNESS_BITS'(MIN_BEST_SHARPNESS_RST);
      end else if (write_en) begin
         case (csr_ch.index)
            CSR_FOCUS_MIN:          focus_min_ff <= csr_ch.data[POSITION_BITS-1:0];
            CSR_FOCUS_MAX:          focus_max_ff <= csr_ch.data[POSITION_BITS-1:0];
            CSR_SCAN_STEP:          scan_step_ff <= csr_ch.data[POSITION_BITS-1:0];
            CSR_TRACK_STEP:         track_step_ff <= csr_ch.data[POSITION_BITS-1:0];
            CSR_DROP_RATIO:         drop_ratio_ff <= csr_ch.data[DROP_RATIO_BITS-1:0];
            CSR_SETTLE_FRAMES:      settle_frames_ff <= csr_ch.data[SETTLE_FRAMES_BITS-1:0];
            CSR_MIN_BEST_SHARPNESS: min_best_sharpness_ff <= csr_ch.data[SHARPNESS_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   assign focus_min          = focus_min_ff;
   assign focus_max          = focus_max_ff;
   assign scan_step          = scan_step_ff;
   assign track_step         = track_step_ff;
   assign drop_ratio         = drop_ratio_ff;
   assign settle_frames      = settle_frames_ff;
   assign min_best_sharpness = min_best_sharpness_ff;

endmodule

[rtl/caf_step.sv]
module caf_step #(
   parameter int POSITION_BITS  = caf_pkg::POSITION_BITS_DEF,
   parameter int SHARPNESS_BITS = caf_pkg::SHARPNESS_BITS_DEF,
   parameter int SETTLE_BITS    = caf_pkg::SETTLE_BITS_DEF
) (
   // Configuration.
   input  logic [POSITION_BITS-1:0]               focus_min,
   input  logic [POSITION_BITS-1:0]               focus_max,
   input  logic [POSITION_BITS-1:0]               scan_step,
   input  logic [POSITION_BITS-1:0]               track_step,
   input  logic [caf_pkg::DROP_RATIO_BITS-1:0]    drop_ratio,
   input  logic [caf_pkg::SETTLE_FRAMES_BITS-1:0] settle_frames,
   input  logic [SHARPNESS_BITS-1:0]              min_best_sharpness,
   // Frame being processed.
   input  logic [SHARPNESS_BITS-1:0]              sharp,
   input  logic [POSITION_BITS-1:0]               pos,
   // Present state.
   input  logic                                   mode_track,
   input  logic [SHARPNESS_BITS-1:0]              best_sharpness,
   input  logic [POSITION_BITS-1:0]               best_position,
   input  logic [SHARPNESS_BITS-1:0]              last_sharpness,
   input  logic                                   moving_down,
   input  logic [SETTLE_BITS-1:0]                 settle_count,
   // Next state; mode and best values are also the result fields.
   output logic                                   mode_track_in,
   output logic [SHARPNESS_BITS-1:0]              best_sharpness_in,
   output logic [POSITION_BITS-1:0]               best_position_in,
   output logic [SHARPNESS_BITS-1:0]              last_sharpness_in,
   output logic                                   moving_down_in,
   output logic [SETTLE_BITS-1:0]                 settle_count_in,
   output logic [POSITION_BITS-1:0]               next_position
);
   import caf_pkg::*;

   localparam int WIDE_BITS  = POSITION_BITS + 2;
   localparam int PROD_BITS  = SHARPNESS_BITS + DROP_RATIO_BITS;

   logic                         settling;
   logic                         beats_best;
   logic [SHARPNESS_BITS-1:0]    upd_sharpness;
   logic [POSITION_BITS-1:0]     upd_position;
   logic [POSITION_BITS:0]       scan_sum;
   logic                         scan_end;
   logic [PROD_BITS-1:0]         sharp_scaled;
   logic [PROD_BITS-1:0]         best_scaled;
   logic                         drop_hit;
   logic                         dir_next;
   logic signed [WIDE_BITS-1:0]  pos_wide;
   logic signed [WIDE_BITS-1:0]  step_wide;
   logic signed [WIDE_BITS-1:0]  track_val;
   logic signed [WIDE_BITS-1:0]  scan_val;
   logic [SETTLE_BITS-1:0]       settle_load;

   // Raise to the low bound, then lower to the high bound (high bound wins).
   function automatic logic [POSITION_BITS-1:0] clamp_pos(
      input logic signed [WIDE_BITS-1:0] v,
      input logic [POSITION_BITS-1:0]    lo,
      input logic [POSITION_BITS-1:0]    hi
   );
      logic signed [WIDE_BITS-1:0] lo_w;
      logic signed [WIDE_BITS-1:0] hi_w;
      logic signed [WIDE_BITS-1:0] r;
      lo_w = $signed({2'b00, lo});
      hi_w = $signed({2'b00, hi});
      r    = v;
      if (r < lo_w) r = lo_w;
      if (r > hi_w) r = hi_w;
      return r[POSITION_BITS-1:0];
   endfunction

   // Best tracking candidate for this frame.
   assign settling      = (settle_count != '0);
   assign beats_best    = (sharp > best_sharpness);
   assign upd_sharpness = beats_best ? sharp : best_sharpness;
   assign upd_position  = beats_best ? pos : best_position;

   // Scan sweep end test.
   assign scan_sum = {1'b0, pos} + {1'b0, scan_step};
   assign scan_end = (scan_sum >= {1'b0, focus_max});
   assign scan_val = scan_end ? $signed({2'b00, upd_position})
                              : $signed({1'b0, scan_sum});

   // Sharpness drop test, exact: sharp * 256 < best * drop_ratio, once best exceeds min_best_sharpness.
   assign sharp_scaled = {{(DROP_RATIO_BITS-8){1'b0}}, sharp, 8'h00};
   assign best_scaled  = PROD_BITS'(best_sharpness) * PROD_BITS'(drop_ratio);
   assign drop_hit     = (best_sharpness > min_best_sharpness) &&
                         (sharp_scaled < best_scaled);

   // Hill climbing step; direction reverses when sharpness falls.
   assign dir_next  = moving_down ^ (sharp < last_sharpness);
   assign pos_wide  = $signed({2'b00, pos});
   assign step_wide = $signed({2'b00, track_step});
   assign track_val = dir_next ? (pos_wide - step_wide) : (pos_wide + step_wide);

   assign settle_load = SETTLE_BITS'(settle_frames);

   // Next state selection by mode.
   always_comb begin
      mode_track_in     = mode_track;
      best_sharpness_in = best_sharpness;
      best_position_in  = best_position;
      last_sharpness_in = last_sharpness;
      moving_down_in    = moving_down;
      settle_count_in   = settle_count;
      next_position     = pos;
      if (settling) begin
         settle_count_in   = settle_count - 1'b1;
         best_sharpness_in = upd_sharpness;
         best_position_in  = upd_position;
      end else if (!mode_track) begin
         best_sharpness_in = upd_sharpness;
         best_position_in  = upd_position;
         next_position     = clamp_pos(scan_val, focus_min, focus_max);
         if (scan_end) begin
            mode_track_in   = 1'b1;
            settle_count_in = settle_load;
         end
      end else if (drop_hit) begin
         mode_track_in     = 1'b0;
         best_sharpness_in = '0;
         best_position_in  = focus_min;
         next_position     = focus_min;
         settle_count_in   = settle_load;
      end else begin
         moving_down_in    = dir_next;
         last_sharpness_in = sharp;
         next_position     = clamp_pos(track_val, focus_min, focus_max);
         best_sharpness_in = upd_sharpness;
         best_position_in  = upd_position;
      end
   end

endmodule

[test/focus_checker.sv]
`timescale 1ns / 1ps

module focus_checker (
   input  logic clock,
   input  logic reset,
   caf_req_if   req_ch,
   caf_rsp_if   rsp_ch,
   caf_csr_if   csr_ch,
   output int   fail_count,
   output int   pending
);
   import caf_pkg::*;

   localparam int PB = POSITION_BITS_DEF;
   localparam int SB = SHARPNESS_BITS_DEF;
   localparam int ST = SETTLE_BITS_DEF;

   typedef struct packed {
      logic [PB-1:0] next_position;
      logic          tracking;
      logic [PB-1:0] best_position;
      logic [SB-1:0] best_sharpness;
   } focus_result_type;

   // Copy of the register file, updated from observed CSR transfers.
   logic [PB-1:0]                 reg_focus_min;
   logic [PB-1:0]                 reg_focus_max;
   logic [PB-1:0]                 reg_scan_step;
   logic [PB-1:0]                 reg_track_step;
   logic [DROP_RATIO_BITS-1:0]    reg_drop_ratio;
   logic [SETTLE_FRAMES_BITS-1:0] reg_settle_frames;
   logic [SB-1:0]                 reg_min_best;

   // Focus state carried from one frame into the next.
   logic          in_track;
   logic [SB-1:0] peak_sharp;
   logic [PB-1:0] peak_pos;
   logic [SB-1:0] prev_sharp;
   logic          stepping_down;
   logic [ST-1:0] settle_left;

   focus_result_type expected_steps[$];

   initial fail_count = 0;

   function automatic void restore_defaults();
      reg_focus_min     = PB'(FOCUS_MIN_RST);
      reg_focus_max     = PB'(FOCUS_MAX_RST);
      reg_scan_step     = PB'(SCAN_STEP_RST);
      reg_track_step    = PB'(TRACK_STEP_RST);
      reg_drop_ratio    = DROP_RATIO_BITS'(DROP_RATIO_RST);
      reg_settle_frames = SETTLE_FRAMES_BITS'(SETTLE_FRAMES_RST);
      reg_min_best      = SB'(MIN_BEST_SHARPNESS_RST);
      in_track          = 1'b0;
      peak_sharp        = '0;
      peak_pos          = '0;
      prev_sharp        = '0;
      stepping_down     = 1'b0;
      settle_left       = '0;
   endfunction

   function automatic void apply_write(input logic [CSR_INDEX_BITS-1:0] idx,
                                       input logic [CSR_DATA_BITS-1:0] value);
      case (idx)
         CSR_FOCUS_MIN:          reg_focus_min     = value[PB-1:0];
         CSR_FOCUS_MAX:          reg_focus_max     = value[PB-1:0];
         CSR_SCAN_STEP:          reg_scan_step     = value[PB-1:0];
         CSR_TRACK_STEP:         reg_track_step    = value[PB-1:0];
         CSR_DROP_RATIO:         reg_drop_ratio    = value[DROP_RATIO_BITS-1:0];
         CSR_SETTLE_FRAMES:      reg_settle_frames = value[SETTLE_FRAMES_BITS-1:0];
         CSR_MIN_BEST_SHARPNESS: reg_min_best      = value[SB-1:0];
         default: ;
      endcase
   endfunction

   // The lower bound is applied first, so the upper bound wins when they cross.
   function automatic logic [PB-1:0] clamp_position(input longint v);
      if (v < longint'(reg_focus_min)) v = longint'(reg_focus_min);
      if (v > longint'(reg_focus_max)) v = longint'(reg_focus_max);
      return v[PB-1:0];
   endfunction

   function automatic void note_best(input logic [SB-1:0] sharp, input logic [PB-1:0] pos);
      if (sharp > peak_sharp) begin
         peak_sharp = sharp;
         peak_pos   = pos;
      end
   endfunction

   // One frame of the hill climb: settle, scan, rescan on a drop, or track.
   function automatic focus_result_type focus_step(input logic [SB-1:0] sharp,
                                                   input logic [PB-1:0] pos);
      focus_result_type r;
      longint           target;
      r.next_position = pos;
      if (settle_left != 0) begin
         settle_left = settle_left - 1'b1;
         note_best(sharp, pos);
      end else if (!in_track) begin
         note_best(sharp, pos);
         target = longint'(pos) + longint'(reg_scan_step);
         if (target >= longint'(reg_focus_max)) begin
            target      = longint'(peak_pos);
            in_track    = 1'b1;
            settle_left = reg_settle_frames;
         end
         r.next_position = clamp_position(target);
      end else if (peak_sharp > reg_min_best &&
                   (longint'(sharp) << 8) < longint'(peak_sharp) * longint'(reg_drop_ratio)) begin
         in_track        = 1'b0;
         peak_sharp      = '0;
         peak_pos        = reg_focus_min;
         r.next_position = reg_focus_min;
         settle_left     = reg_settle_frames;
      end else begin
         if (sharp < prev_sharp) stepping_down = !stepping_down;
         prev_sharp = sharp;
         target = stepping_down ? longint'(pos) - longint'(reg_track_step)
                                : longint'(pos) + longint'(reg_track_step);
         r.next_position = clamp_position(target);
         note_best(sharp, pos);
      end
      r.tracking       = in_track;
      r.best_position  = peak_pos;
      r.best_sharpness = peak_sharp;
      return r;
   endfunction

   function automatic void check_field(input string field, input logic [31:0] want_v,
                                       input logic [31:0] got_v);
      if (got_v !== want_v) begin
         $error("%s mismatch: expected %0d, got %0d", field, want_v, got_v);
         fail_count++;
      end
   endfunction

   // Watch all three channels; a transfer is counted at the edge where it happens.
   always @(posedge clock) begin
      focus_result_type want;
      if (reset) begin
         restore_defaults();
         expected_steps.delete();
      end else begin
         if (csr_ch.valid && csr_ch.ready) apply_write(csr_ch.index, csr_ch.data);
         if (req_ch.valid && req_ch.ready)
            expected_steps.push_back(focus_step(req_ch.frame_sharpness,
                                                req_ch.current_position));
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_steps.size() == 0) begin
               $error("response transfer with no frame outstanding: next_position %0d",
                      rsp_ch.next_position);
               fail_count++;
            end else begin
               want = expected_steps.pop_front();
               check_field("next_position", 32'(want.next_position),
                           32'(rsp_ch.next_position));
               check_field("tracking", 32'(want.tracking), 32'(rsp_ch.tracking));
               check_field("best_position_out", 32'(want.best_position),
                           32'(rsp_ch.best_position_out));
               check_field("best_sharpness_out", 32'(want.best_sharpness),
                           32'(rsp_ch.best_sharpness_out));
            end
         end
      end
      pending = expected_steps.size();
   end

endmodule

[test/tb_contrast_autofocus_hill_climb.sv]
`timescale 1ns / 1ps

module tb_contrast_autofocus_hill_climb;
   import caf_pkg::*;

   localparam int PB            = POSITION_BITS_DEF;
   localparam int SB            = SHARPNESS_BITS_DEF;
   localparam int PHASES        = 8;
   localparam int FRAMES_PER    = 210;
   localparam int LONG_HOLD     = 200;
   localparam int QUIET_CYCLES  = 4;
   localparam int TIMEOUT_NS    = 6_000_000;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED_INDEX = 3'd7;

   typedef struct {
      logic [PB-1:0]                 focus_min;
      logic [PB-1:0]                 focus_max;
      logic [PB-1:0]                 scan_step;
      logic [PB-1:0]                 track_step;
      logic [DROP_RATIO_BITS-1:0]    drop_ratio;
      logic [SETTLE_FRAMES_BITS-1:0] settle_frames;
      logic [SB-1:0]                 min_best_sharpness;
   } focus_settings_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending;

   // Traffic shaping for the sender and the receiver.
   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;
   int hold_seq      = 0;

   // Lens and scene used to shape sharpness like a real focus curve.
   focus_settings_type cfg;
   int lens;
   int focus_peak;
   int focus_slope;

   caf_req_if req_ch ();
   caf_rsp_if rsp_ch ();
   caf_csr_if csr_ch ();

   contrast_autofocus_hill_climb dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   focus_checker focus_watch (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .csr_ch     (csr_ch),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Receiver: random stalls, plus a long hold-off whenever one is requested.
   always @(posedge clock) begin
      int hold_left;
      int hold_seen;
      if (hold_seq != hold_seen) begin
         hold_seen = hold_seq;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task automatic send_frame(input logic [SB-1:0] sharp, input logic [PB-1:0] pos);
      while ($urandom_range(99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid            <= 1'b1;
      req_ch.frame_sharpness  <= sharp;
      req_ch.current_position <= pos;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Leaves valid high; the caller lowers it after the last write.
   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx, input logic [31:0] value,
                            input int width);
      logic [31:0] keep;
      keep = (32'd1 << width) - 1;
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      // Bits above the register width are sometimes set and must be dropped.
      csr_ch.data  <= ($urandom_range(3) == 0) ? ((value & keep) | ($urandom & ~keep))
                                               : (value & keep);
      do @(posedge clock); while (!csr_ch.ready);
   endtask

   task automatic program_regs(input focus_settings_type s, input bit with_unused);
      write_reg(CSR_FOCUS_MIN, 32'(s.focus_min), PB);
      write_reg(CSR_FOCUS_MAX, 32'(s.focus_max), PB);
      write_reg(CSR_SCAN_STEP, 32'(s.scan_step), PB);
      write_reg(CSR_TRACK_STEP, 32'(s.track_step), PB);
      write_reg(CSR_DROP_RATIO, 32'(s.drop_ratio), DROP_RATIO_BITS);
      write_reg(CSR_SETTLE_FRAMES, 32'(s.settle_frames), SETTLE_FRAMES_BITS);
      write_reg(CSR_MIN_BEST_SHARPNESS, 32'(s.min_best_sharpness), SB);
      if (with_unused) write_reg(CSR_UNUSED_INDEX, $urandom, 32);
      csr_ch.valid <= 1'b0;
   endtask

   // Stop sending and wait until every frame has produced its response.
   task automatic wait_quiet();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_edge16();
      case ($urandom_range(5))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic focus_settings_type random_settings();
      focus_settings_type s;
      s.focus_min          = ($urandom_range(2) == 0) ? pick_edge16()
                                                      : 16'($urandom_range(4000));
      s.focus_max          = ($urandom_range(2) == 0) ? pick_edge16()
                                                      : 16'($urandom_range(65535, 20000));
      s.scan_step          = ($urandom_range(3) == 0) ? pick_edge16()
                                                      : 16'($urandom_range(2048, 64));
      s.track_step         = ($urandom_range(3) == 0) ? pick_edge16()
                                                      : 16'($urandom_range(512, 1));
      s.drop_ratio         = ($urandom_range(3) == 0) ? 9'($urandom_range(511))
                                                      : 9'($urandom_range(256, 100));
      s.settle_frames      = ($urandom_range(5) == 0) ? 8'hFF : 8'($urandom_range(4));
      s.min_best_sharpness = ($urandom_range(3) == 0) ? pick_edge16()
                                                      : 16'($urandom_range(8000));
      return s;
   endfunction

   function automatic focus_settings_type phase_settings(input int phase);
      focus_settings_type s;
      case (phase)
         0: s = '{PB'(FOCUS_MIN_RST), PB'(FOCUS_MAX_RST), PB'(SCAN_STEP_RST),
                  PB'(TRACK_STEP_RST), DROP_RATIO_BITS'(DROP_RATIO_RST),
                  SETTLE_FRAMES_BITS'(SETTLE_FRAMES_RST), SB'(MIN_BEST_SHARPNESS_RST)};
         1: s = '{16'd0, 16'hFFFF, 16'd4096, 16'd1, 9'd256, 8'd0, 16'd0};
         // No scan progress, huge track steps, long settling, rescans disabled.
         2: s = '{16'd1000, 16'd60000, 16'd0, 16'hFFFF, 9'd0, 8'hFF, 16'hFFFF};
         // Crossed bounds: the upper bound sits below the lower one.
         3: s = '{16'd50000, 16'd10000, 16'd512, 16'd300, 9'd511, 8'd1, 16'd100};
         4: s = '{16'd0, 16'd0, 16'hFFFF, 16'd0, 9'd128, 8'd3, 16'd0};
         default: s = random_settings();
      endcase
      return s;
   endfunction

   // Mostly frames from a lens moving over a focus curve, with some pure noise.
   task automatic send_random_frame();
      int offset;
      int level;
      int pick;
      if ($urandom_range(99) < 15) begin
         send_frame(SB'($urandom), PB'($urandom));
      end else begin
         pick = $urandom_range(9);
         if (pick < 5) lens = lens + int'(cfg.scan_step);
         else if (pick < 8) lens = $urandom_range(1) ? lens + int'(cfg.track_step)
                                                     : lens - int'(cfg.track_step);
         else if (pick == 8) lens = int'(cfg.focus_min);
         else lens = $urandom_range(65535);
         if (lens > 65535 || lens > int'(cfg.focus_max) + int'(cfg.scan_step))
            lens = int'(cfg.focus_min);
         if (lens < 0) lens = 0;
         offset = lens - focus_peak;
         if (offset < 0) offset = -offset;
         level = 60000 - offset * focus_slope + int'($urandom_range(2000)) - 1000;
         // Occasional sudden loss of contrast, as when the scene changes.
         if ($urandom_range(99) < 8) level = level / 4;
         if (level < 0) level = 0;
         if (level > 65535) level = 65535;
         send_frame(SB'(level), PB'(lens));
      end
   endtask

   initial begin
      req_ch.valid            = 1'b0;
      req_ch.frame_sharpness  = '0;
      req_ch.current_position = '0;
      rsp_ch.ready            = 1'b0;
      csr_ch.valid            = 1'b0;
      csr_ch.index            = '0;
      csr_ch.data             = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed frames on the reset settings: a sweep into track mode,
      // settling, a direction reversal, a rescan on a drop and clamping.
      send_frame(16'h0000, 16'd0);
      send_frame(16'h1000, 16'd512);
      send_frame(16'h8000, 16'd1024);
      send_frame(16'h4000, 16'd1536);
      send_frame(16'hFFFF, 16'd25088);
      send_frame(16'h1000, 16'd25088);
      send_frame(16'h2000, 16'd25088);
      send_frame(16'hFFFF, 16'd25088);
      send_frame(16'hF000, 16'd25216);
      send_frame(16'h1000, 16'd25088);
      send_frame(16'h0000, 16'd0);
      send_frame(16'hFFFF, 16'hFFFF);
      send_frame(16'h0000, 16'hFFFF);
      send_frame(16'hFFFF, 16'h0000);
      send_frame(16'h8000, 16'd25600);
      send_frame(16'hFFFF, 16'd0);
      send_frame(16'hC000, 16'd0);
      send_frame(16'h0000, 16'd0);
      wait_quiet();

      // Random phases, each with its own settings and traffic pattern.
      for (int phase = 0; phase < PHASES; phase++) begin
         cfg = phase_settings(phase);
         program_regs(cfg, phase == 0);
         case (phase % 4)
            0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_idle_pct = 55; rsp_stall_pct = 0;  end
            2: begin req_idle_pct = 0;  rsp_stall_pct = 55; end
            default: begin req_idle_pct = 8; rsp_stall_pct = 8; end
         endcase
         lens        = int'(cfg.focus_min);
         focus_peak  = (cfg.focus_max > cfg.focus_min)
                       ? $urandom_range(int'(cfg.focus_max), int'(cfg.focus_min))
                       : $urandom_range(65535);
         focus_slope = $urandom_range(4, 1);
         for (int n = 0; n < FRAMES_PER; n++) begin
            // Hold the response side off while frames keep coming.
            if (phase == 4 && n == 50) hold_seq = hold_seq + 1;
            send_random_frame();
         end
         wait_quiet();
      end

      if (fail_count == 0 && pending == 0)
         $display("contrast_autofocus_hill_climb verification clean");
      else
         $display("contrast_autofocus_hill_climb verification failed");
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("contrast_autofocus_hill_climb verification failed");
      $finish;
   end

endmodule
